[src/fpfa_pkg.sv]
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	// fixed field widths of the stream and config ports
	localparam int MODE_W      = 2;
	localparam int NUM_W       = 5;
	localparam int BIDX_W      = 4;
	localparam int SVAL_W      = 16;
	localparam int BNUM_W      = 4;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 8;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] CFG_FIT_MODE   = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_NUM_BLOCKS = 1'd1;

	localparam logic [NUM_W-1:0] NUM_BLOCKS_RST = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WB,
		ST_DONE
	} st_t;

	// table write port
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     addr;
		logic [SIZE_BITS-1:0] data;
	} wr_t;

	// compare unit verdict for one entry
	typedef struct packed {
		logic fit;
		logic take;
		logic stop;
	} cmp_t;

endpackage

[src/fpfa_table.sv]
// ----------------------------------------------------------------------------
// fpfa_table
// Partition size table: one write port, one read port at the scan index.
// ----------------------------------------------------------------------------
module fpfa_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fpfa_pkg::wr_t                  wr,
	input  logic [fpfa_pkg::IDX_W-1:0]     rd_addr,
	output logic [fpfa_pkg::SIZE_BITS-1:0] rd_data
);
	import fpfa_pkg::*;

	logic [SIZE_BITS-1:0] size_q [MAX_BLOCKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				size_q[i] <= '0;
			end
		end else if (wr.en) begin
			size_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = size_q[rd_addr];

endmodule

[src/fpfa_cmp.sv]
// ----------------------------------------------------------------------------
// fpfa_cmp
// Shared compare unit: judges one table entry against the request and the
// best candidate so far.
// ----------------------------------------------------------------------------
module fpfa_cmp (
	input  logic [fpfa_pkg::SIZE_BITS-1:0] entry_size,
	input  logic [fpfa_pkg::SIZE_BITS-1:0] want,
	input  logic [fpfa_pkg::SIZE_BITS-1:0] best,
	input  logic                           found,
	input  logic [fpfa_pkg::MODE_W-1:0]    fit_mode,
	output fpfa_pkg::cmp_t                 res
);
	import fpfa_pkg::*;

	logic first_mode;
	logic better;

	always_comb begin
		// unused mode code behaves as first fit
		first_mode = (fit_mode != FIT_BEST) && (fit_mode != FIT_WORST);
		better     = ((fit_mode == FIT_BEST) && (entry_size < best)) ||
		             ((fit_mode == FIT_WORST) && (entry_size > best));
		res.fit    = (entry_size >= want);
		res.take   = res.fit && (!found || better);
		res.stop   = res.fit && first_mode;
	end

endmodule

[src/fpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: takes items, walks the table one entry per cycle, writes back
// the consumed entry and holds the result register.
// ----------------------------------------------------------------------------
module fpfa_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [fpfa_pkg::BIDX_W-1:0]    block_index,
	input  logic [fpfa_pkg::SVAL_W-1:0]    size_value,
	input  logic [fpfa_pkg::NUM_W-1:0]     num_blocks,
	output logic [fpfa_pkg::IDX_W-1:0]     rd_addr,
	input  logic [fpfa_pkg::SIZE_BITS-1:0] rd_data,
	output logic [fpfa_pkg::SIZE_BITS-1:0] want,
	output logic [fpfa_pkg::SIZE_BITS-1:0] best,
	output logic                           found,
	input  fpfa_pkg::cmp_t                 cmp,
	output fpfa_pkg::wr_t                  wr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           granted,
	output logic [fpfa_pkg::BNUM_W-1:0]    block_number
);
	import fpfa_pkg::*;

	st_t                  st_q, st_nxt;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     lim;
	logic [SIZE_BITS-1:0] want_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [IDX_W-1:0]     sel_q;
	logic                 found_q;
	logic                 out_valid_q;
	logic                 granted_q;
	logic [BNUM_W-1:0]    bnum_q;

	logic take_in;
	logic take_alloc;
	logic take_load;
	logic last;
	logic scan_en;
	logic wb_en;
	logic out_load;

	assign take_in    = in_valid && in_ready;
	assign take_alloc = take_in && (req_type == REQ_ALLOC);
	assign take_load  = take_in && (req_type == REQ_LOAD);
	assign last       = ({1'b0, idx_q} + CNT_W'(1)) == lim_q;

	always_comb begin
		if (int'(num_blocks) > MAX_BLOCKS) begin
			lim = CNT_W'(MAX_BLOCKS);
		end else begin
			lim = CNT_W'(num_blocks);
		end
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (take_alloc) begin
					st_nxt = (lim == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp.stop || last) begin
					st_nxt = ST_WB;
				end
			end
			ST_WB: begin
				st_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = (st_q == ST_IDLE);
		scan_en  = (st_q == ST_SCAN);
		wb_en    = (st_q == ST_WB) && found_q;
		out_load = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// table write: loads on transfer, zero on write-back
	always_comb begin
		wr = '0;
		if (take_load) begin
			wr.en   = (int'(block_index) < MAX_BLOCKS);
			wr.addr = IDX_W'(block_index);
			wr.data = SIZE_BITS'(size_value);
		end else if (wb_en) begin
			wr.en   = 1'b1;
			wr.addr = sel_q;
			wr.data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (take_alloc) begin
				found_q <= 1'b0;
			end else if (scan_en && cmp.take) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_alloc) begin
			want_q <= SIZE_BITS'(size_value);
			best_q <= '0;
			sel_q  <= '0;
			idx_q  <= '0;
			lim_q  <= lim;
		end else if (scan_en) begin
			if (cmp.take) begin
				best_q <= rd_data;
				sel_q  <= idx_q;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
		if (out_load) begin
			granted_q <= found_q;
			bnum_q    <= found_q ? BNUM_W'(sel_q) : '0;
		end
	end

	assign rd_addr      = idx_q;
	assign want         = want_q;
	assign best         = best_q;
	assign found        = found_q;
	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign block_number = bnum_q;

endmodule

[src/fixed_partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// First, best or worst fit allocation over a table of fixed partitions.
// ----------------------------------------------------------------------------
// load transfer: no result, next item taken the following cycle
// allocate: accept, scan of N = min(num_blocks,16) entries, write-back, result
//   (first fit stops at the first hit); write-back zeroes the chosen entry
// the table is walked one entry per cycle through a single compare unit
// reset: fit_mode first fit, num_blocks 16, all partition sizes zero
module fixed_partition_fit_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fpfa_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [3:0] block_index, [19:4] size_value, [23:20] zero
	input  logic [fpfa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [3:0] block_number, [7:4] zero
	output logic [fpfa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// [0] granted
	output logic                            m_axis_tuser
);
	import fpfa_pkg::*;

	logic [MODE_W-1:0]    fit_mode_q;
	logic [NUM_W-1:0]     num_blocks_q;
	logic [IDX_W-1:0]     rd_addr;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] want;
	logic [SIZE_BITS-1:0] best;
	logic                 found;
	cmp_t                 cmp;
	wr_t                  wr;
	logic [BNUM_W-1:0]    block_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			num_blocks_q <= NUM_BLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FIT_MODE:   fit_mode_q   <= cfg_wdata[MODE_W-1:0];
				CFG_NUM_BLOCKS: num_blocks_q <= cfg_wdata[NUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fpfa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fpfa_cmp u_cmp (
		.entry_size (rd_data),
		.want       (want),
		.best       (best),
		.found      (found),
		.fit_mode   (fit_mode_q),
		.res        (cmp)
	);

	fpfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.req_type     (s_axis_tuser),
		.block_index  (s_axis_tdata[BIDX_W-1:0]),
		.size_value   (s_axis_tdata[BIDX_W+SVAL_W-1:BIDX_W]),
		.num_blocks   (num_blocks_q),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.want         (want),
		.best         (best),
		.found        (found),
		.cmp          (cmp),
		.wr           (wr),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.granted      (m_axis_tuser),
		.block_number (block_number)
	);

	assign m_axis_tdata = {(M_TDATA_W - BNUM_W)'(0), block_number};

	// an accepted allocation keeps the input closed for the next cycle
	a_busy_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_ALLOC)
		|=> !s_axis_tready)
		else $error("input ready right after an allocate transfer");

	// a refused request reports block zero
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (block_number == '0))
		else $error("nonzero block number without grant");

	// a granted block lies inside the searched range
	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> ({1'b0, block_number} < num_blocks_q))
		else $error("granted block outside searched range");

endmodule
